/* hdl/hrbd_pkg.sv */
// Shared types and constants for the heart rate beat detector.
// Used by hrbd_ctrl, hrbd_datapath and heart_rate_beat_detector; no dependencies.
package hrbd_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int JUMP_W      = 13;
   localparam int TICK_W      = 16;
   localparam int PERIOD_W    = 10;
   localparam int BPM_W       = 8;
   localparam int MS_W        = TICK_W + PERIOD_W;
   localparam int DIVIDEND_W  = 16;
   localparam int DIV_STEPS   = DIVIDEND_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = PERIOD_W;

   localparam int WINDOW_LEN_DEFAULT = 32;

   localparam logic [DIVIDEND_W-1:0] BPM_DIVIDEND = DIVIDEND_W'(60000);
   localparam logic [SAMPLE_W-1:0]   SAMPLE_TOP   = {SAMPLE_W{1'b1}};
   localparam logic [JUMP_W-1:0]     JUMP_RESET   = JUMP_W'(4096);
   localparam logic [PERIOD_W-1:0]   PERIOD_RESET = PERIOD_W'(20);
   localparam logic [BPM_W-1:0]      CEIL_RESET   = BPM_W'(200);
   localparam logic [BPM_W-1:0]      FLOOR_RESET  = BPM_W'(30);

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BPM_CEILING   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BPM_FLOOR     = 2'd2;

   typedef struct packed {
      logic sample_load;
      logic mul_load;
      logic div_step;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic beat_found;
   } dp_status_type;

endpackage

/* hdl/heart_rate_beat_detector.sv */
// Heart rate beat detector: adaptive-threshold pulse detection with BPM output.
// Top level joining hrbd_ctrl and hrbd_datapath; depends on hrbd_pkg.
//
// Usage: one 12-bit pulse sample is taken per handshake on the req_ channel
// (req_valid / req_stall). Every second falling crossing of the adaptive
// midpoint with a positive tick interval yields one result on the rsp_
// channel: the clamped beats per minute and the interval in samples.
// Throughput: samples that give no result flow at one per cycle while no
// beat result is in progress. A sample that completes a beat is followed
// by the tick-by-period multiply, the bit-per-cycle restoring divider of
// 60000 by the interval in ms, and the load of the output register;
// req_stall is high meanwhile.
// A result held by rsp_stall does not block new samples; only a following
// result waits in its last step until the output register is free.
// Configuration must be written through csr_write / csr_index / csr_wdata
// only while the block is idle (unchecked by the block); index 3 is ignored.
// Reset (synchronous, active high) restores the register defaults (20 ms,
// ceiling 200, floor 30), clears the detector state and drops rsp_valid.
module heart_rate_beat_detector #(
   parameter int WINDOW_LEN = hrbd_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [hrbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hrbd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [hrbd_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [hrbd_pkg::BPM_W-1:0]       rsp_bpm,
   output logic [hrbd_pkg::TICK_W-1:0]      rsp_interval_ticks
);
   import hrbd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   hrbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hrbd_datapath #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_sample         (req_sample),
      .cmd                (cmd),
      .status             (status),
      .rsp_bpm            (rsp_bpm),
      .rsp_interval_ticks (rsp_interval_ticks)
   );

endmodule

/* hdl/hrbd_ctrl.sv */
// Controller for the heart rate beat detector: sequences sample update,
// interval multiply, divide and result hand-off. Depends on hrbd_pkg.
module hrbd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  hrbd_pkg::dp_status_type status,
   output hrbd_pkg::dp_cmd_type    cmd
);
   import hrbd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.sample_load = accept;
            if (accept && status.beat_found) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the quotient until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/hrbd_datapath.sv */
// Datapath for the heart rate beat detector: adaptive threshold state,
// edge timing, interval multiplier, restoring divider and output register.
// Depends on hrbd_pkg.
module hrbd_datapath #(
   parameter int WINDOW_LEN = hrbd_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [hrbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hrbd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [hrbd_pkg::SAMPLE_W-1:0]       req_sample,
   input  hrbd_pkg::dp_cmd_type                cmd,
   output hrbd_pkg::dp_status_type             status,
   output logic [hrbd_pkg::BPM_W-1:0]          rsp_bpm,
   output logic [hrbd_pkg::TICK_W-1:0]         rsp_interval_ticks
);
   import hrbd_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_LEN + 1);

   // configuration
   logic [PERIOD_W-1:0] period_ff;
   logic [BPM_W-1:0]    ceiling_ff;
   logic [BPM_W-1:0]    floor_ff;

   // detector state
   logic [SAMPLE_W-1:0] prev_ff;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] mid_ff, mid_in;
   logic [JUMP_W-1:0]   jump_ff, jump_in;
   logic                level_ff, level_in;
   logic                parity_ff;
   logic [TICK_W-1:0]   tick_ff;
   logic [TICK_W-1:0]   first_ff;

   // divider
   logic [TICK_W-1:0]     beat_ticks_ff;
   logic [MS_W-1:0]       ms_ff;
   logic [MS_W-1:0]       rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;

   logic [TICK_W-1:0] rsp_ticks_ff;
   logic [BPM_W-1:0]  rsp_bpm_ff;

   logic signed [SAMPLE_W+1:0] rise;
   logic                       in_window;
   logic                       close;
   logic [SAMPLE_W-1:0]        max_upd, min_upd;
   logic [SAMPLE_W:0]          extreme_sum;
   logic                       fall_edge;
   logic [MS_W:0]              rem_shift;
   logic                       q_bit;
   logic [BPM_W-1:0]           bpm_capped;
   logic [BPM_W-1:0]           bpm_clamped;

   always_comb begin
      rise      = $signed({2'b00, req_sample}) - $signed({2'b00, prev_ff});
      in_window = rise < $signed({1'b0, jump_ff});
      max_upd   = (in_window && (req_sample > max_ff)) ? req_sample : max_ff;
      min_upd   = (in_window && (req_sample < min_ff)) ? req_sample : min_ff;
      fill_in   = in_window ? fill_ff + 1'b1 : fill_ff;
      close     = (fill_in >= FILL_W'(WINDOW_LEN));
      extreme_sum = {1'b0, max_upd} + {1'b0, min_upd};
      mid_in  = mid_ff;
      jump_in = jump_ff;
      max_in  = max_upd;
      min_in  = min_upd;
      if (close) begin
         fill_in = '0;
         mid_in  = extreme_sum[SAMPLE_W:1];
         jump_in = (max_upd >= min_upd) ?
                   {1'b0, SAMPLE_W'(max_upd - min_upd) >> 1} : '0;
         max_in  = '0;
         min_in  = SAMPLE_TOP;
      end
      level_in  = (req_sample > mid_in);
      fall_edge = level_ff && !level_in;
      // an even edge gives a beat only if the interval is positive
      status.beat_found = fall_edge && parity_ff && (tick_ff > first_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         ceiling_ff <= CEIL_RESET;
         floor_ff   <= FLOOR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SAMPLE_PERIOD: period_ff  <= csr_wdata;
            CSR_BPM_CEILING:   ceiling_ff <= csr_wdata[BPM_W-1:0];
            CSR_BPM_FLOOR:     floor_ff   <= csr_wdata[BPM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         fill_ff   <= '0;
         max_ff    <= '0;
         min_ff    <= SAMPLE_TOP;
         mid_ff    <= '0;
         jump_ff   <= JUMP_RESET;
         level_ff  <= 1'b0;
         parity_ff <= 1'b0;
         tick_ff   <= '0;
         first_ff  <= '0;
      end else if (cmd.sample_load) begin
         prev_ff  <= req_sample;
         fill_ff  <= fill_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
         mid_ff   <= mid_in;
         jump_ff  <= jump_in;
         level_ff <= level_in;
         if (fall_edge) begin
            parity_ff <= ~parity_ff;
            if (!parity_ff) begin
               first_ff <= tick_ff;
            end else begin
               tick_ff <= '0;
            end
         end else begin
            tick_ff <= tick_ff + 1'b1;
         end
      end
   end

   // restoring division of the fixed dividend by the interval in ms;
   // a zero divisor leaves all ones, which the ceiling then caps
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      q_bit     = (rem_shift >= {1'b0, ms_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_load) begin
         beat_ticks_ff <= tick_ff - first_ff;
      end
      if (cmd.mul_load) begin
         ms_ff  <= beat_ticks_ff * period_ff;
         rem_ff <= '0;
         quo_ff <= BPM_DIVIDEND;
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? MS_W'(rem_shift - {1'b0, ms_ff}) : rem_shift[MS_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], q_bit};
      end
   end

   always_comb begin
      bpm_capped  = (quo_ff > {{(DIVIDEND_W-BPM_W){1'b0}}, ceiling_ff}) ?
                    ceiling_ff : quo_ff[BPM_W-1:0];
      bpm_clamped = (bpm_capped < floor_ff) ? floor_ff : bpm_capped;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_bpm_ff   <= bpm_clamped;
         rsp_ticks_ff <= beat_ticks_ff;
      end
   end

   assign rsp_bpm            = rsp_bpm_ff;
   assign rsp_interval_ticks = rsp_ticks_ff;

endmodule
